// ===== rtl/tile_map_sprite_culler_unit_assert.svh =====
// Assertion macros shared by the tile map sprite culler RTL.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef TILE_MAP_SPRITE_CULLER_UNIT_ASSERT_SVH
`define TILE_MAP_SPRITE_CULLER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TMSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmsc: implication check failed");

// Next-cycle implication, off while reset is asserted.
`define TMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmsc: next-cycle check failed");

`endif

// ===== rtl/tmsc_pkg.sv =====
// Shared types and fixed constants of the tile map sprite culler.
// Used by tmsc_front, tmsc_queue, tmsc_back and the top level.
`default_nettype none

package tmsc_pkg;

    localparam int TILE_PX       = 16;
    localparam int TILE_SHIFT    = 4;
    localparam int ATLAS_SHIFT   = 2;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int SPRITE_GROUPS = 4;
    localparam int GROUP_SIZE    = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam int POS_W   = 16;
    localparam int TILE_W  = 8;
    localparam int GROUP_W = 2;
    localparam int SLOT_W  = 4;
    localparam int SX_W    = 11;
    localparam int SY_W    = 10;
    localparam int TEX_X_W = 6;
    localparam int TEX_Y_W = 10;
    // Screen coordinate math before culling.
    localparam int CALC_W  = 18;

    localparam logic [GROUP_W-1:0] FIRST_GROUP = GROUP_W'(1);
    localparam logic [GROUP_W-1:0] LAST_GROUP  = GROUP_W'(SPRITE_GROUPS - 1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(GROUP_SIZE - 1);

    typedef enum logic [1:0] {
        OP_RENDER = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic {
        KIND_SLOT = 1'b0,
        KIND_TILE = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_READ
    } t_back_state;

    typedef struct packed {
        t_op                       op;
        logic                      in_map;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic        [TILE_W-1:0]  tile;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/tmsc_front.sv =====
// Front stage: accepts input items, maps screen points to map cells, drops no-ops.
// Depends on tmsc_pkg.
`default_nettype none

module tmsc_front #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 32,
    parameter int ADDR_W     = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_op,
    input  logic signed [tmsc_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [tmsc_pkg::POS_W-1:0] i_pos_y,
    input  logic [tmsc_pkg::TILE_W-1:0]       i_tile_in,
    input  logic                              i_clearing,
    output logic                              o_push,
    output tmsc_pkg::t_cmd                    o_cmd,
    output logic [ADDR_W-1:0]                 o_addr,
    input  logic                              i_push_ready
);
    import tmsc_pkg::*;

    localparam int COL_W = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
    localparam int ROW_W = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
    localparam int Q_W   = POS_W + 1;

    logic              r_valid;
    logic              n_valid;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;

    logic                  take;
    logic signed [Q_W-1:0] col_num;
    logic signed [Q_W-1:0] col_adj;
    logic signed [Q_W-1:0] col_q;
    logic signed [Q_W-1:0] row_num;
    logic signed [Q_W-1:0] row_adj;
    logic signed [Q_W-1:0] row_q;
    logic                  in_map;
    logic [ADDR_W-1:0]     map_cell;
    t_cmd                  new_cmd;

    assign o_in_stall = i_clearing || (r_valid && !i_push_ready);
    assign take       = i_in_valid && !o_in_stall;

    // Division by the tile size truncates toward zero: bias negative values first.
    always_comb begin
        col_num = {i_pos_x[POS_W-1], i_pos_x};
        col_adj = col_num[Q_W-1] ? col_num + Q_W'(TILE_PX - 1) : col_num;
        col_q   = col_adj >>> TILE_SHIFT;
        row_num = $signed(Q_W'(SCREEN_HEIGHT)) - $signed({i_pos_y[POS_W-1], i_pos_y});
        row_adj = row_num[Q_W-1] ? row_num + Q_W'(TILE_PX - 1) : row_num;
        row_q   = row_adj >>> TILE_SHIFT;
        in_map  = !col_q[Q_W-1] && (col_q < $signed(Q_W'(MAP_WIDTH)))
               && !row_q[Q_W-1] && (row_q < $signed(Q_W'(MAP_HEIGHT)));
        map_cell = ADDR_W'(ADDR_W'(row_q[ROW_W-1:0]) * ADDR_W'(MAP_WIDTH)
                   + ADDR_W'(col_q[COL_W-1:0]));
        new_cmd.op     = t_op'(i_op);
        new_cmd.in_map = in_map;
        new_cmd.pos_x  = i_pos_x;
        new_cmd.pos_y  = i_pos_y;
        new_cmd.tile   = i_tile_in;
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (take && (t_op'(i_op) != OP_NOP)) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd  <= new_cmd;
            r_addr <= map_cell;
        end
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;
    assign o_addr = r_addr;

endmodule

`default_nettype wire

// ===== rtl/tmsc_queue.sv =====
// Short command queue between the front and back stages.
// Depends on tmsc_pkg and the shared assertion macros.
`default_nettype none
`include "tile_map_sprite_culler_unit_assert.svh"

module tmsc_queue #(
    parameter int W = 47
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_head_valid,
    output logic [W-1:0] o_head_data,
    input  logic         i_pop
);
    import tmsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [W-1:0]     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [CNT_W-1:0] n_count;
    logic             push_ok;

    assign o_ready      = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_data  = r_mem[r_rp];
    assign push_ok      = i_push && o_ready;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (push_ok) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
        end
        if (push_ok && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push_ok && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `TMSC_ASSERT_IMPLIES(a_q_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `TMSC_ASSERT_IMPLIES(a_q_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `TMSC_ASSERT_NEXT(a_q_pop_drains, i_clk, i_rst_n, i_pop && !push_ok, r_count == CNT_W'($past(r_count) - 1'b1))

endmodule

`default_nettype wire

// ===== rtl/tmsc_back.sv =====
// Back stage: owns the tile map, clears it after reset, runs render scans,
// reads and writes, and holds the result register. Depends on tmsc_pkg.
`default_nettype none
`include "tile_map_sprite_culler_unit_assert.svh"

module tmsc_back #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 32,
    parameter int ADDR_W     = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_head_valid,
    input  tmsc_pkg::t_cmd                      i_head_cmd,
    input  logic [ADDR_W-1:0]                   i_head_addr,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_kind,
    output logic [tmsc_pkg::GROUP_W-1:0]        o_group,
    output logic [tmsc_pkg::SLOT_W-1:0]         o_slot,
    output logic signed [tmsc_pkg::SX_W-1:0]    o_screen_x,
    output logic signed [tmsc_pkg::SY_W-1:0]    o_screen_y,
    output logic [tmsc_pkg::TEX_X_W-1:0]        o_tex_x,
    output logic [tmsc_pkg::TEX_Y_W-1:0]        o_tex_y,
    output logic                                o_hidden,
    output logic [tmsc_pkg::TILE_W-1:0]         o_tile_out,
    output logic                                o_last
);
    import tmsc_pkg::*;

    localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int COL_W = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
    localparam int ROW_W = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(MAP_WIDTH - 1);

    // Tile map storage, single port, registered read.
    logic [TILE_W-1:0] mem [CELLS];
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [TILE_W-1:0] mem_wdata;
    logic [TILE_W-1:0] r_rd;

    t_back_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    logic signed [POS_W-1:0] r_cam_x, n_cam_x;
    logic signed [POS_W-1:0] r_cam_y, n_cam_y;
    logic [COL_W-1:0]        r_i, n_i;
    logic [ROW_W-1:0]        r_j, n_j;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic                    r_issue_done, n_issue_done;
    logic                    r_s1_valid, n_s1_valid;
    logic signed [CALC_W-1:0] r_s1_sx, n_s1_sx;
    logic signed [CALC_W-1:0] r_s1_sy, n_s1_sy;
    logic [GROUP_W-1:0]      r_grp, n_grp;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic                    r_hit, n_hit;

    logic                    r_o_valid, n_o_valid;
    t_kind                   r_o_kind, n_o_kind;
    logic [GROUP_W-1:0]      r_o_group, n_o_group;
    logic [SLOT_W-1:0]       r_o_slot, n_o_slot;
    logic signed [SX_W-1:0]  r_o_sx, n_o_sx;
    logic signed [SY_W-1:0]  r_o_sy, n_o_sy;
    logic [TEX_X_W-1:0]      r_o_tx, n_o_tx;
    logic [TEX_Y_W-1:0]      r_o_ty, n_o_ty;
    logic                    r_o_hidden, n_o_hidden;
    logic [TILE_W-1:0]       r_o_tile, n_o_tile;
    logic                    r_o_last, n_o_last;

    logic                     out_free;
    logic                     at_last;
    logic                     visible;
    logic                     scan_end;
    logic [TILE_W-1:0]        code_m1;
    logic [CALC_W-1:0]        row_top;
    logic signed [CALC_W-1:0] sx0;
    logic signed [CALC_W-1:0] sy0;

    assign out_free = !r_o_valid || !i_out_stall;
    assign at_last  = (r_grp == LAST_GROUP) && (r_slot == LAST_SLOT);
    assign code_m1  = r_rd - 1'b1;

    // Screen position of the tile being issued.
    always_comb begin
        row_top = (CALC_W'(r_j) + 1'b1) << TILE_SHIFT;
        sx0 = $signed(CALC_W'(r_i) << TILE_SHIFT)
            - $signed({{(CALC_W - POS_W){r_cam_x[POS_W-1]}}, r_cam_x});
        sy0 = $signed(CALC_W'(SCREEN_HEIGHT)) - $signed(row_top)
            - $signed({{(CALC_W - POS_W){r_cam_y[POS_W-1]}}, r_cam_y});
    end

    // Cull empty cells, and cull against the screen with a one-tile margin on the low side of each axis.
    assign visible = (r_rd != '0)
                  && (r_s1_sx >= -TILE_PX) && (r_s1_sx < SCREEN_WIDTH)
                  && (r_s1_sy >= -TILE_PX) && (r_s1_sy < SCREEN_HEIGHT);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_cam_x      = r_cam_x;
        n_cam_y      = r_cam_y;
        n_i          = r_i;
        n_j          = r_j;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_s1_valid   = r_s1_valid;
        n_s1_sx      = r_s1_sx;
        n_s1_sy      = r_s1_sy;
        n_grp        = r_grp;
        n_slot       = r_slot;
        n_hit        = r_hit;
        n_o_valid    = r_o_valid;
        n_o_kind     = r_o_kind;
        n_o_group    = r_o_group;
        n_o_slot     = r_o_slot;
        n_o_sx       = r_o_sx;
        n_o_sy       = r_o_sy;
        n_o_tx       = r_o_tx;
        n_o_ty       = r_o_ty;
        n_o_hidden   = r_o_hidden;
        n_o_tile     = r_o_tile;
        n_o_last     = r_o_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_addr;
        mem_wdata    = '0;
        o_pop        = 1'b0;
        scan_end     = 1'b0;

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                if (r_clr_addr == LAST_CELL) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    case (i_head_cmd.op)
                        OP_RENDER: begin
                            n_cam_x      = i_head_cmd.pos_x;
                            n_cam_y      = i_head_cmd.pos_y;
                            n_i          = '0;
                            n_j          = '0;
                            n_addr       = '0;
                            n_issue_done = 1'b0;
                            n_s1_valid   = 1'b0;
                            n_grp        = FIRST_GROUP;
                            n_slot       = '0;
                            n_state      = ST_SCAN;
                        end
                        OP_READ: begin
                            n_hit    = i_head_cmd.in_map;
                            mem_re   = i_head_cmd.in_map;
                            mem_addr = i_head_addr;
                            n_state  = ST_READ;
                        end
                        OP_WRITE: begin
                            mem_we    = i_head_cmd.in_map;
                            mem_addr  = i_head_addr;
                            mem_wdata = i_head_cmd.tile;
                        end
                        default: begin
                            // no-ops never reach the queue; drop
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_TILE;
                    n_o_group  = '0;
                    n_o_slot   = '0;
                    n_o_sx     = '0;
                    n_o_sy     = '0;
                    n_o_tx     = '0;
                    n_o_ty     = '0;
                    n_o_hidden = 1'b0;
                    n_o_tile   = r_hit ? r_rd : '0;
                    n_o_last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // Advance both scan stages only when the result register can take a slot.
                if (out_free) begin
                    if (r_s1_valid && visible) begin
                        n_o_valid  = 1'b1;
                        n_o_kind   = KIND_SLOT;
                        n_o_group  = r_grp;
                        n_o_slot   = r_slot;
                        n_o_sx     = r_s1_sx[SX_W-1:0];
                        n_o_sy     = r_s1_sy[SY_W-1:0];
                        n_o_tx     = TEX_X_W'(code_m1[ATLAS_SHIFT-1:0]) << TILE_SHIFT;
                        n_o_ty     = TEX_Y_W'(code_m1[TILE_W-1:ATLAS_SHIFT]) << TILE_SHIFT;
                        n_o_hidden = 1'b0;
                        n_o_tile   = '0;
                        n_o_last   = at_last;
                        if (at_last) begin
                            scan_end   = 1'b1;
                            n_s1_valid = 1'b0;
                            n_state    = ST_IDLE;
                        end else if (r_slot == LAST_SLOT) begin
                            n_slot = '0;
                            n_grp  = r_grp + 1'b1;
                        end else begin
                            n_slot = r_slot + 1'b1;
                        end
                    end
                    if (!scan_end) begin
                        if (!r_issue_done) begin
                            mem_re     = 1'b1;
                            mem_addr   = r_addr;
                            n_s1_valid = 1'b1;
                            n_s1_sx    = sx0;
                            n_s1_sy    = sy0;
                            n_addr     = r_addr + 1'b1;
                            if (r_i == LAST_COL) begin
                                n_i = '0;
                                n_j = r_j + 1'b1;
                            end else begin
                                n_i = r_i + 1'b1;
                            end
                            if (r_addr == LAST_CELL) begin
                                n_issue_done = 1'b1;
                            end
                        end else begin
                            n_s1_valid = 1'b0;
                            n_state    = ST_FILL;
                        end
                    end
                end
            end
            ST_FILL: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_SLOT;
                    n_o_group  = r_grp;
                    n_o_slot   = r_slot;
                    n_o_sx     = SX_W'(SCREEN_WIDTH);
                    n_o_sy     = SY_W'(SCREEN_HEIGHT);
                    n_o_tx     = '0;
                    n_o_ty     = '0;
                    n_o_hidden = 1'b1;
                    n_o_tile   = '0;
                    n_o_last   = at_last;
                    if (at_last) begin
                        n_state = ST_IDLE;
                    end else if (r_slot == LAST_SLOT) begin
                        n_slot = '0;
                        n_grp  = r_grp + 1'b1;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_grp        <= FIRST_GROUP;
            r_slot       <= '0;
            r_hit        <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_i          <= n_i;
            r_j          <= n_j;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_s1_valid   <= n_s1_valid;
            r_grp        <= n_grp;
            r_slot       <= n_slot;
            r_hit        <= n_hit;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cam_x    <= n_cam_x;
        r_cam_y    <= n_cam_y;
        r_s1_sx    <= n_s1_sx;
        r_s1_sy    <= n_s1_sy;
        r_o_kind   <= n_o_kind;
        r_o_group  <= n_o_group;
        r_o_slot   <= n_o_slot;
        r_o_sx     <= n_o_sx;
        r_o_sy     <= n_o_sy;
        r_o_tx     <= n_o_tx;
        r_o_ty     <= n_o_ty;
        r_o_hidden <= n_o_hidden;
        r_o_tile   <= n_o_tile;
        r_o_last   <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[mem_addr];
        end
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_group     = r_o_group;
    assign o_slot      = r_o_slot;
    assign o_screen_x  = r_o_sx;
    assign o_screen_y  = r_o_sy;
    assign o_tex_x     = r_o_tx;
    assign o_tex_y     = r_o_ty;
    assign o_hidden    = r_o_hidden;
    assign o_tile_out  = r_o_tile;
    assign o_last      = r_o_last;

    `TMSC_ASSERT_IMPLIES(a_clear_no_output, i_clk, i_rst_n, r_state == ST_CLEAR, !r_o_valid)
    `TMSC_ASSERT_IMPLIES(a_mem_one_access, i_clk, i_rst_n, mem_we, !mem_re)
    `TMSC_ASSERT_IMPLIES(a_last_slot_pos, i_clk, i_rst_n, r_o_valid && r_o_kind == KIND_SLOT && r_o_last, r_o_group == LAST_GROUP && r_o_slot == LAST_SLOT)
    `TMSC_ASSERT_NEXT(a_fill_done_idle, i_clk, i_rst_n, r_state == ST_FILL && out_free && at_last, r_state == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/tile_map_sprite_culler_unit.sv =====
// Top level of the tile map sprite culler: front stage, command queue, back stage.
// Depends on tmsc_pkg, tmsc_front, tmsc_queue and tmsc_back.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-------------------------------------
//   in      | input     | i_in_valid / o_in_stall     | op, pos_x, pos_y, tile_in
//   out     | output    | o_out_valid / i_out_stall   | kind .. tile_out, last
//
// Render: the pop, then one map cell per cycle over MAP_WIDTH*MAP_HEIGHT cells while the
// output is not stalled, then the last read finishes, stopping early once all slots are
// filled; then one hidden slot per cycle while the output is not stalled.
// Read pops the command and reads the map, then loads the result register from the read data;
// write pops the command and writes the map.
// After reset the map is cleared one cell per cycle over all MAP_WIDTH*MAP_HEIGHT cells;
// o_in_stall stays high for that pass.
// A stalled output holds the scan in place; the queue lets the front keep taking items until it is full.
`default_nettype none

module tile_map_sprite_culler_unit #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic signed [tmsc_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [tmsc_pkg::POS_W-1:0]   i_pos_y,
    input  logic [tmsc_pkg::TILE_W-1:0]         i_tile_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_kind,
    output logic [tmsc_pkg::GROUP_W-1:0]        o_group,
    output logic [tmsc_pkg::SLOT_W-1:0]         o_slot,
    output logic signed [tmsc_pkg::SX_W-1:0]    o_screen_x,
    output logic signed [tmsc_pkg::SY_W-1:0]    o_screen_y,
    output logic [tmsc_pkg::TEX_X_W-1:0]        o_tex_x,
    output logic [tmsc_pkg::TEX_Y_W-1:0]        o_tex_y,
    output logic                                o_hidden,
    output logic [tmsc_pkg::TILE_W-1:0]         o_tile_out,
    output logic                                o_last
);
    import tmsc_pkg::*;

    localparam int CELLS  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CMD_W  = $bits(t_cmd);
    localparam int Q_W    = CMD_W + ADDR_W;

    logic              clearing;
    logic              push;
    logic              push_ready;
    t_cmd              front_cmd;
    logic [ADDR_W-1:0] front_addr;
    logic              head_valid;
    logic [Q_W-1:0]    head_data;
    logic              pop;

    tmsc_front #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_tile_in    (i_tile_in),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .o_addr       (front_addr),
        .i_push_ready (push_ready)
    );

    tmsc_queue #(
        .W (Q_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       ({front_cmd, front_addr}),
        .o_ready      (push_ready),
        .o_head_valid (head_valid),
        .o_head_data  (head_data),
        .i_pop        (pop)
    );

    tmsc_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_cmd   (t_cmd'(head_data[Q_W-1:ADDR_W])),
        .i_head_addr  (head_data[ADDR_W-1:0]),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_group      (o_group),
        .o_slot       (o_slot),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_tex_x      (o_tex_x),
        .o_tex_y      (o_tex_y),
        .o_hidden     (o_hidden),
        .o_tile_out   (o_tile_out),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== tb/tmsc_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the tile map sprite culler: watches both channels, keeps its own tile map,
// works out the sprite slots and tile answers and compares them. Depends on tmsc_pkg.
module tmsc_checker #(
    parameter int MAP_W = 64,
    parameter int MAP_H = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [1:0]                          i_op,
    input  logic signed [tmsc_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [tmsc_pkg::POS_W-1:0]   i_pos_y,
    input  logic [tmsc_pkg::TILE_W-1:0]         i_tile_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_kind,
    input  logic [tmsc_pkg::GROUP_W-1:0]        i_group,
    input  logic [tmsc_pkg::SLOT_W-1:0]         i_slot,
    input  logic signed [tmsc_pkg::SX_W-1:0]    i_screen_x,
    input  logic signed [tmsc_pkg::SY_W-1:0]    i_screen_y,
    input  logic [tmsc_pkg::TEX_X_W-1:0]        i_tex_x,
    input  logic [tmsc_pkg::TEX_Y_W-1:0]        i_tex_y,
    input  logic                                i_hidden,
    input  logic [tmsc_pkg::TILE_W-1:0]         i_tile_out,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import tmsc_pkg::*;

    localparam int MAP_CELLS  = MAP_W * MAP_H;
    localparam int SLOT_TOTAL = (SPRITE_GROUPS - 1) * GROUP_SIZE;
    localparam int ATLAS_COLS = 4;

    typedef struct packed {
        logic                kind;
        logic [GROUP_W-1:0]  group;
        logic [SLOT_W-1:0]   slot;
        logic [SX_W-1:0]     screen_x;
        logic [SY_W-1:0]     screen_y;
        logic [TEX_X_W-1:0]  tex_x;
        logic [TEX_Y_W-1:0]  tex_y;
        logic                hidden;
        logic [TILE_W-1:0]   tile_out;
        logic                last;
    } t_culler_answer;

    logic [TILE_W-1:0] tile_map [MAP_CELLS];
    t_culler_answer    pending_answers [$];
    int                fail_count = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic bit find_tile(input int x, input int y, output int map_idx);
        int col;
        int row;
        // Integer division truncates toward zero, as the block does.
        col = x / TILE_PX;
        row = (SCREEN_HEIGHT - y) / TILE_PX;
        map_idx = row * MAP_W + col;
        return col >= 0 && col < MAP_W && row >= 0 && row < MAP_H;
    endfunction

    task automatic queue_slot(input int n, input int sx, input int sy, input int atlas_idx,
                              input bit parked);
        t_culler_answer entry;
        entry          = '0;
        entry.kind     = KIND_SLOT;
        entry.group    = GROUP_W'(n / GROUP_SIZE + 1);
        entry.slot     = SLOT_W'(n % GROUP_SIZE);
        entry.screen_x = SX_W'(sx);
        entry.screen_y = SY_W'(sy);
        entry.hidden   = parked;
        entry.last     = (n == SLOT_TOTAL - 1);
        if (!parked) begin
            entry.tex_x = TEX_X_W'((atlas_idx % ATLAS_COLS) * TILE_PX);
            entry.tex_y = TEX_Y_W'((atlas_idx / ATLAS_COLS) * TILE_PX);
        end
        pending_answers.push_back(entry);
    endtask

    task automatic cull_sprites(input int cam_x, input int cam_y);
        int filled;
        int sx;
        int sy;
        logic [TILE_W-1:0] code;
        filled = 0;
        for (int row = 0; row < MAP_H && filled < SLOT_TOTAL; row++) begin
            for (int col = 0; col < MAP_W && filled < SLOT_TOTAL; col++) begin
                code = tile_map[row * MAP_W + col];
                sx   = col * TILE_PX - cam_x;
                sy   = SCREEN_HEIGHT - (row + 1) * TILE_PX - cam_y;
                if (code != '0 && sx >= -TILE_PX && sx < SCREEN_WIDTH &&
                    sy >= -TILE_PX && sy < SCREEN_HEIGHT) begin
                    queue_slot(filled, sx, sy, int'(code) - 1, 1'b0);
                    filled++;
                end
            end
        end
        // Park the rest offscreen.
        while (filled < SLOT_TOTAL) begin
            queue_slot(filled, SCREEN_WIDTH, SCREEN_HEIGHT, 0, 1'b1);
            filled++;
        end
    endtask

    task automatic take_command();
        int map_idx;
        t_culler_answer entry;
        case (t_op'(i_op))
            OP_RENDER: cull_sprites(i_pos_x, i_pos_y);
            OP_READ: begin
                entry      = '0;
                entry.kind = KIND_TILE;
                entry.last = 1'b1;
                if (find_tile(i_pos_x, i_pos_y, map_idx)) begin
                    entry.tile_out = tile_map[map_idx];
                end
                pending_answers.push_back(entry);
            end
            OP_WRITE: begin
                if (find_tile(i_pos_x, i_pos_y, map_idx)) begin
                    tile_map[map_idx] = i_tile_in;
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_answer();
        t_culler_answer want;
        if (pending_answers.size() == 0) begin
            $error("unexpected result: kind %0d slot %0d tile_out %0d",
                   i_kind, i_slot, i_tile_out);
            fail_count++;
        end else begin
            want = pending_answers.pop_front();
            compare_field("kind", want.kind, i_kind);
            compare_field("group", want.group, i_group);
            compare_field("slot", want.slot, i_slot);
            compare_field("screen_x", $signed(want.screen_x), $signed(i_screen_x));
            compare_field("screen_y", $signed(want.screen_y), $signed(i_screen_y));
            compare_field("tex_x", want.tex_x, i_tex_x);
            compare_field("tex_y", want.tex_y, i_tex_y);
            compare_field("hidden", want.hidden, i_hidden);
            compare_field("tile_out", want.tile_out, i_tile_out);
            compare_field("last", want.last, i_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAP_CELLS; k++) begin
                tile_map[k] = '0;
            end
            pending_answers.delete();
        end else begin
            // Results at this edge belong to earlier commands: check before taking a new one.
            if (i_out_valid && !i_out_stall) begin
                check_answer();
            end
            if (i_in_valid && !i_in_stall) begin
                take_command();
            end
        end
        pending_count = pending_answers.size();
    end

endmodule

// ===== tb/tb_tile_map_sprite_culler_unit.sv =====
`timescale 1ns / 100ps
// Test top for tile_map_sprite_culler_unit: clock, reset, directed and random commands,
// output back-pressure and the verdict. Depends on tmsc_pkg and tmsc_checker.
module tb_tile_map_sprite_culler_unit;
    import tmsc_pkg::*;

    localparam int MAP_W        = 64;
    localparam int MAP_H        = 32;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 4000;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 op;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic [TILE_W-1:0]          tile_in;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       kind;
    logic [GROUP_W-1:0]         group;
    logic [SLOT_W-1:0]          slot;
    logic signed [SX_W-1:0]     screen_x;
    logic signed [SY_W-1:0]     screen_y;
    logic [TEX_X_W-1:0]         tex_x;
    logic [TEX_Y_W-1:0]         tex_y;
    logic                       hidden;
    logic [TILE_W-1:0]          tile_out;
    logic                       last;

    int   fail_count;
    int   pending;
    int   send_idle_pct  = 26;
    int   recv_stall_pct = 71;
    logic hold_output    = 1'b0;
    logic pressure_start = 1'b0;
    int   cycle_count    = 0;

    tile_map_sprite_culler_unit #(
        .MAP_WIDTH  (MAP_W),
        .MAP_HEIGHT (MAP_H)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_op        (op),
        .i_pos_x     (pos_x),
        .i_pos_y     (pos_y),
        .i_tile_in   (tile_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_kind      (kind),
        .o_group     (group),
        .o_slot      (slot),
        .o_screen_x  (screen_x),
        .o_screen_y  (screen_y),
        .o_tex_x     (tex_x),
        .o_tex_y     (tex_y),
        .o_hidden    (hidden),
        .o_tile_out  (tile_out),
        .o_last      (last)
    );

    tmsc_checker #(
        .MAP_W (MAP_W),
        .MAP_H (MAP_H)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_op         (op),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_tile_in    (tile_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_kind       (kind),
        .i_group      (group),
        .i_slot       (slot),
        .i_screen_x   (screen_x),
        .i_screen_y   (screen_y),
        .i_tex_x      (tex_x),
        .i_tex_y      (tex_y),
        .i_hidden     (hidden),
        .i_tile_out   (tile_out),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= hold_output || ($urandom_range(99) < recv_stall_pct);
    end

    // Hold off the output long enough for the command queue to back up.
    initial begin
        wait (pressure_start);
        @(posedge clk);
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_op cmd, input int x, input int y, input int code);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= cmd;
        pos_x    <= POS_W'(x);
        pos_y    <= POS_W'(y);
        tile_in  <= TILE_W'(code);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_item(output bit counted);
        int pick;
        int x;
        int y;
        int code;
        pick    = $urandom_range(99);
        counted = 1'b1;
        // Mostly points near the map, sometimes anywhere in the 16-bit range.
        if ($urandom_range(99) < 85) begin
            x = span(-40, 1040);
            y = span(-48, 512);
        end else begin
            x = $urandom;
            y = $urandom;
        end
        code = ($urandom_range(99) < 80) ? int'($urandom_range(255, 1)) : 0;
        if (pick < 4) begin
            send_item(OP_NOP, x, y, code);
            counted = 1'b0;
        end else if (pick < 48) begin
            send_item(OP_WRITE, x, y, code);
        end else if (pick < 70) begin
            send_item(OP_READ, x, y, $urandom_range(255));
        end else begin
            if ($urandom_range(99) < 80) begin
                x = span(-660, 1040);
                y = span(-500, 500);
            end
            send_item(OP_RENDER, x, y, $urandom_range(255));
        end
    endtask

    initial begin
        int sent;
        bit counted;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = OP_NOP;
        pos_x    = '0;
        pos_y    = '0;
        tile_in  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Empty map: every slot parked.
        send_item(OP_RENDER, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        // Corners of the map, smallest and largest codes, last atlas column.
        send_item(OP_WRITE, 0, 480, 1);
        send_item(OP_WRITE, 1023, -31, 255);
        send_item(OP_WRITE, 16, 464, 4);
        // Points just off each edge and far outside: drop.
        send_item(OP_WRITE, -16, 0, 9);
        send_item(OP_WRITE, 1024, 0, 9);
        send_item(OP_WRITE, 0, 497, 9);
        send_item(OP_WRITE, 0, -32, 9);
        send_item(OP_WRITE, -32768, -32768, 9);
        // Negative offsets truncate toward zero onto column 0 and row 0.
        send_item(OP_READ, -15, 495, 0);
        send_item(OP_READ, 1023, -31, 0);
        send_item(OP_READ, 32767, 32767, 0);
        send_item(OP_READ, -32768, -32768, 0);
        send_item(OP_NOP, 0, 480, 7);
        send_item(OP_RENDER, 0, 0, 0);
        // Tiles sitting exactly on the margin and just past the far edges.
        send_item(OP_RENDER, 1024, -32, 0);
        send_item(OP_RENDER, -640, 0, 0);
        send_item(OP_RENDER, -624, 480, 0);
        send_item(OP_RENDER, 0, -16, 0);
        send_item(OP_RENDER, 32767, -32768, 0);
        send_item(OP_WRITE, -1, 481, 0);
        send_item(OP_READ, 0, 480, 0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS / 3) begin
                send_idle_pct  = 71;
                recv_stall_pct = 26;
            end else if (sent == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                pressure_start = 1'b1;
            end
            send_random_item(counted);
            if (counted) begin
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
